>>> rtl/pcm_downmix_to_mono16_core_assert.svh
// ----------------------------------------------------------------------------
// pcm_downmix_to_mono16_core_assert.svh
// assertion macros for the mono downmix core
// ----------------------------------------------------------------------------
`ifndef PCM_DOWNMIX_TO_MONO16_CORE_ASSERT_SVH
`define PCM_DOWNMIX_TO_MONO16_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define PDM16_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define PDM16_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define PDM16_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define PDM16_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/pdm16_pkg.sv
// ----------------------------------------------------------------------------
// pdm16_pkg
// shared types and constants of the mono downmix core
// ----------------------------------------------------------------------------
package pdm16_pkg;

   // widths of the fixed-point path
   localparam int SUM_W    = 43;   // running channel sum, signed
   localparam int DEC_W    = 41;   // one decoded sample, signed
   localparam int STEP_W   = 6;    // divider step counter
   localparam int FMT_W    = 3;
   localparam int CCNT_W   = 4;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 4;
   localparam int MONO_W   = 16;
   localparam int MEAN_W   = 32;   // clamped mean magnitude, up to 2^31

   // sample format codes
   typedef enum logic [FMT_W-1:0] {
      FMT_FLOAT32 = 3'd0,
      FMT_INT16   = 3'd1,
      FMT_INT24   = 3'd2,
      FMT_INT32   = 3'd3,
      FMT_UINT8   = 3'd4,
      FMT_NONE    = 3'd5
   } sample_format_type;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLE_FORMAT = 1'd0,
      CSR_CHANNEL_COUNT = 1'd1
   } csr_index_type;

   localparam logic [FMT_W-1:0]  FMT_RESET  = FMT_INT16;
   localparam logic [CCNT_W-1:0] CCNT_RESET = 4'd2;

   // float decode constants
   localparam logic [7:0] FLT_EXP_MAX  = 8'd255;
   localparam logic [7:0] FLT_EXP_SAT  = 8'd135;
   localparam logic [7:0] FLT_EXP_UNIT = 8'd119;

   // divider status
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

>>> rtl/pdm16_decode.sv
// ----------------------------------------------------------------------------
// pdm16_decode
// converts one raw channel sample to signed fixed point in units of 2^-31
// ----------------------------------------------------------------------------
module pdm16_decode (
   input  logic [pdm16_pkg::FMT_W-1:0]        sample_format,
   input  logic [31:0]                        sample_word,
   output logic signed [pdm16_pkg::DEC_W-1:0] sample_fix
);
   import pdm16_pkg::*;

   logic [7:0]         flt_exp;
   logic [22:0]        flt_man;
   logic [23:0]        flt_m;
   logic [7:0]         flt_e;
   logic [7:0]         flt_lsh;
   logic [7:0]         flt_rsh;
   logic [DEC_W-2:0]   flt_mag;
   logic [DEC_W-1:0]   flt_fix;

   // float32: truncate toward zero, saturate at 256.0, nan is zero
   always_comb begin
      flt_exp = sample_word[30:23];
      flt_man = sample_word[22:0];
      flt_m   = (flt_exp != 8'd0) ? {1'b1, flt_man} : {1'b0, flt_man};
      flt_e   = (flt_exp != 8'd0) ? flt_exp : 8'd1;
      flt_lsh = flt_e - FLT_EXP_UNIT;
      flt_rsh = FLT_EXP_UNIT - flt_e;
      if (flt_exp >= FLT_EXP_SAT) begin
         flt_mag = {1'b1, {(DEC_W-2){1'b0}}};
      end else if (flt_e >= FLT_EXP_UNIT) begin
         flt_mag = {{(DEC_W-25){1'b0}}, flt_m} << flt_lsh[3:0];
      end else if (flt_rsh >= 8'd32) begin
         flt_mag = '0;
      end else begin
         flt_mag = {{(DEC_W-25){1'b0}}, flt_m} >> flt_rsh[4:0];
      end
      if ((flt_exp == FLT_EXP_MAX) && (flt_man != 23'd0)) begin
         flt_fix = '0;
      end else if (sample_word[31]) begin
         flt_fix = -{1'b0, flt_mag};
      end else begin
         flt_fix = {1'b0, flt_mag};
      end
   end

   // format select
   always_comb begin
      unique case (sample_format)
         FMT_FLOAT32: sample_fix = flt_fix;
         FMT_INT16:   sample_fix = {{9{sample_word[15]}}, sample_word[15:0], 16'd0};
         FMT_INT24:   sample_fix = {{9{sample_word[23]}}, sample_word[23:0], 8'd0};
         FMT_INT32:   sample_fix = {{9{sample_word[31]}}, sample_word};
         FMT_UINT8:   sample_fix = {{9{~sample_word[7]}}, ~sample_word[7],
                                    sample_word[6:0], 24'd0};
         default:     sample_fix = '0;
      endcase
   end

endmodule

>>> rtl/pdm16_div.sv
// ----------------------------------------------------------------------------
// pdm16_div
// restoring serial divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pdm16_div #(
   parameter int CNT_W = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pdm16_pkg::SUM_W-1:0]   dividend,
   input  logic [CNT_W-1:0]              divisor,
   output logic [pdm16_pkg::SUM_W-1:0]   quotient,
   output pdm16_pkg::div_status_type     status
);
   import pdm16_pkg::*;

   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  dsr_ff, dsr_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W:0]    trial;
   logic              fits;

   // one shift-subtract step
   always_comb begin
      trial   = {rem_ff, quo_ff[SUM_W-1]};
      fits    = (trial >= {1'b0, dsr_ff});
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         step_in = STEP_W'(SUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[SUM_W-2:0], fits};
         rem_in  = fits ? CNT_W'(trial - {1'b0, dsr_ff}) : trial[CNT_W-1:0];
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

>>> rtl/pcm_downmix_to_mono16_core.sv
// ----------------------------------------------------------------------------
// pcm_downmix_to_mono16_core
// interleaved multichannel pcm to 16-bit mono downmix
// ----------------------------------------------------------------------------
// Channel samples arrive on the req_ channel (valid/ready), one per
// transaction, interleaved; csr_ writes set the sample format and the
// channel count, to be made while the core is idle (the core itself does
// not enforce this). Each sample is decoded to fixed point and added into
// a saturating 43-bit sum in the cycle after it is taken, so a sample that
// does not close a frame passes through the accumulate state before the
// core returns to idle. The sample that closes a frame starts a serial
// divide of the sum magnitude by the channel count, one quotient bit per
// cycle; the quotient is then clamped and scaled by 32767 for rsp_.
// req_ready is high only while the core waits for a sample.
// The finished mono sample sits in an output register; the core keeps
// taking samples of the next frame while it waits, and holds its final
// step only if the previous result has still not been taken.
// Synchronous reset clears the sum, channel position and packet mark,
// drops rsp_valid and sets format int16 with two channels.
// ----------------------------------------------------------------------------
`include "pcm_downmix_to_mono16_core_assert.svh"

module pcm_downmix_to_mono16_core #(
   parameter int MAX_CHANNELS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // channel sample input
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [31:0]                        req_sample_word,
   input  logic                               req_packet_end_in,
   // mono sample output
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [pdm16_pkg::MONO_W-1:0] rsp_mono_sample,
   output logic                               rsp_packet_end_out,
   // register writes
   input  logic                               csr_write_en,
   input  logic [pdm16_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pdm16_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import pdm16_pkg::*;

   localparam int CNT_W = $clog2(MAX_CHANNELS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACC,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type                state_ff, state_in;
   logic [FMT_W-1:0]         fmt_ff;
   logic [CCNT_W-1:0]        ccnt_ff;
   logic [31:0]              word_ff;
   logic                     mark_word_ff;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]         pos_ff, pos_in;
   logic                     mark_ff, mark_in;
   logic                     frame_neg_ff, frame_neg_in;
   logic                     frame_mark_ff, frame_mark_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [MONO_W-1:0] rsp_mono_ff, rsp_mono_in;
   logic                     rsp_mark_ff, rsp_mark_in;

   logic signed [DEC_W-1:0]  dec_fix;
   logic signed [SUM_W:0]    sum_wide;
   logic signed [SUM_W-1:0]  sum_sat;
   logic [4:0]               ccnt_one;
   logic [4:0]               ccnt_lim;
   logic [CNT_W-1:0]         ccnt_eff;
   logic [CNT_W-1:0]         pos_next;
   logic                     frame_done;
   logic [SUM_W-1:0]         sum_mag;
   logic                     div_start;
   logic [SUM_W-1:0]         div_quo;
   div_status_type           div_status;
   logic [MEAN_W-1:0]        mean_mag;
   logic [MEAN_W+14:0]       prod;
   logic [MONO_W-1:0]        scaled_mag;
   logic                     out_free;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff  <= FMT_RESET;
         ccnt_ff <= CCNT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SAMPLE_FORMAT: fmt_ff  <= csr_wdata[FMT_W-1:0];
            CSR_CHANNEL_COUNT: ccnt_ff <= csr_wdata[CCNT_W-1:0];
            default: ;
         endcase
      end
   end

   // effective channel count, zero as one, capped at the maximum
   always_comb begin
      ccnt_one = (ccnt_ff == '0) ? 5'd1 : {1'b0, ccnt_ff};
      ccnt_lim = (ccnt_one > 5'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS) : ccnt_one;
      ccnt_eff = ccnt_lim[CNT_W-1:0];
   end

   pdm16_decode u_decode (
      .sample_format (fmt_ff),
      .sample_word   (word_ff),
      .sample_fix    (dec_fix)
   );

   // saturating accumulate and frame end detect
   always_comb begin
      sum_wide = {sum_ff[SUM_W-1], sum_ff} +
                 {{(SUM_W-DEC_W+1){dec_fix[DEC_W-1]}}, dec_fix};
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                   : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[SUM_W-1:0];
      end
      pos_next   = pos_ff + CNT_W'(1);
      frame_done = (pos_next >= ccnt_eff);
      sum_mag    = sum_sat[SUM_W-1] ? (~sum_sat + SUM_W'(1)) : sum_sat;
   end

   pdm16_div #(
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_mag),
      .divisor  (ccnt_eff),
      .quotient (div_quo),
      .status   (div_status)
   );

   // clamp mean to 1.0 and scale by 32767 with truncation
   always_comb begin
      mean_mag   = (div_quo > SUM_W'(33'h1_0000_0000 >> 1))
                   ? {1'b1, {(MEAN_W-1){1'b0}}} : div_quo[MEAN_W-1:0];
      prod       = {mean_mag, 15'd0} - {15'd0, mean_mag};
      scaled_mag = {1'b0, prod[MEAN_W+13:MEAN_W-1]};
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      sum_in        = sum_ff;
      pos_in        = pos_ff;
      mark_in       = mark_ff;
      frame_neg_in  = frame_neg_ff;
      frame_mark_in = frame_mark_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_mono_in   = rsp_mono_ff;
      rsp_mark_in   = rsp_mark_ff;
      div_start     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_ACC;
         end
         ST_ACC: begin
            if (frame_done) begin
               div_start     = 1'b1;
               frame_neg_in  = sum_sat[SUM_W-1];
               frame_mark_in = mark_ff || mark_word_ff;
               sum_in        = '0;
               pos_in        = '0;
               mark_in       = 1'b0;
               state_in      = ST_DIV;
            end else begin
               sum_in   = sum_sat;
               pos_in   = pos_next;
               mark_in  = mark_ff || mark_word_ff;
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_status.done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_mono_in  = frame_neg_ff ? -$signed(scaled_mag) : $signed(scaled_mag);
               rsp_mark_in  = frame_mark_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         pos_ff       <= '0;
         mark_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         pos_ff       <= pos_in;
         mark_ff      <= mark_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      frame_neg_ff  <= frame_neg_in;
      frame_mark_ff <= frame_mark_in;
      rsp_mono_ff   <= rsp_mono_in;
      rsp_mark_ff   <= rsp_mark_in;
   end

   // capture the accepted transaction
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         word_ff      <= req_sample_word;
         mark_word_ff <= req_packet_end_in;
      end
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mono_sample    = rsp_mono_ff;
   assign rsp_packet_end_out = rsp_mark_ff;

   // checks
   `PDM16_ASSERT_IMPLIES(a_div_busy_blocks_input, clock, reset,
      div_status.busy, !req_ready)
   `PDM16_ASSERT_NEXT(a_div_done_to_out, clock, reset,
      div_status.done, state_ff == ST_OUT)
   `PDM16_ASSERT_IMPLIES(a_mono_in_range, clock, reset,
      rsp_valid_ff, rsp_mono_ff != {1'b1, {(MONO_W-1){1'b0}}})

endmodule

>>> tb/sv/pcm_downmix_to_mono16_core_tb.sv
// ----------------------------------------------------------------------------
// pcm_downmix_to_mono16_core_tb
// self-checking testbench of the multichannel to 16-bit mono downmix core
// ----------------------------------------------------------------------------
// Channel samples are queued by the main sequence and offered by a clocked
// driver; every accepted sample is run through a local downmix predictor that
// keeps its own frame sum, position, packet mark and register copies. Mono
// samples are checked in order as they leave the core. A directed part hits
// format corners and float special values, then random phases sweep every
// format code, corner and random channel counts, with varied sender and receiver idling.
// ----------------------------------------------------------------------------
module pcm_downmix_to_mono16_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pdm16_pkg::*;

   localparam int CLK_PERIOD    = 8;
   localparam int MAX_CH        = 8;
   localparam int SETTLE_CYCLES = 60;
   localparam int TAIL_CYCLES   = 100;
   localparam int HOLD_CYCLES   = 500;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int RANDOM_PHASES = 16;

   localparam longint UNIT_ONE    = longint'(1) <<< 31;
   localparam longint FLOAT_LIMIT = longint'(1) <<< 39;
   localparam longint SUM_HI      = (longint'(1) <<< 42) - 1;
   localparam longint SUM_LO      = -(longint'(1) <<< 42);

   typedef struct {
      logic [31:0] word;
      logic        mark;
      bit          drain_first;   // hold this sample until no frame is outstanding
   } channel_sample_type;

   typedef struct {
      logic signed [MONO_W-1:0] mono;
      logic                     mark;
   } mono_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [31:0]               req_sample_word = '0;
   logic                      req_packet_end_in = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [MONO_W-1:0]  rsp_mono_sample;
   logic                      rsp_packet_end_out;
   logic                      csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   // sample queue, expected mono samples and bookkeeping
   channel_sample_type pending_samples[$];
   mono_result_type    expected_mono[$];
   int samples_queued   = 0;
   int samples_accepted = 0;
   int frames_checked   = 0;
   int mismatches       = 0;
   int settings_used    = 0;
   int cycle_count      = 0;

   // idling control
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit hold_request   = 1'b0;
   bit hold_started   = 1'b0;
   int hold_left      = 0;

   // predictor copies of registers and frame state
   logic [FMT_W-1:0]  fmt_copy = FMT_INT16;
   logic [CCNT_W-1:0] count_copy = 4'd2;
   longint            frame_sum = 0;
   int                frame_position = 0;
   bit                frame_mark = 1'b0;

   pcm_downmix_to_mono16_core #(
      .MAX_CHANNELS(MAX_CH)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample_word   (req_sample_word),
      .req_packet_end_in (req_packet_end_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_mono_sample   (rsp_mono_sample),
      .rsp_packet_end_out(rsp_packet_end_out),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // float32 to 2^-31 fixed: truncate, saturate at 256.0, nan is zero
   function automatic longint float_to_fixed(logic [31:0] w);
      logic [7:0]  ex;
      logic [22:0] frac;
      longint      mant;
      longint      mag;
      int          e;
      ex   = w[30:23];
      frac = w[22:0];
      if (ex == 8'hFF) begin
         if (frac != 0)
            return 0;
         mag = FLOAT_LIMIT;
      end else if (ex >= 8'd135) begin
         mag = FLOAT_LIMIT;
      end else begin
         mant = (ex != 0) ? longint'({1'b1, frac}) : longint'(frac);
         e    = (ex != 0) ? int'(ex) : 1;
         if (e >= 119)
            mag = mant <<< (e - 119);
         else
            mag = (119 - e >= 32) ? 0 : (mant >> (119 - e));
      end
      return w[31] ? -mag : mag;
   endfunction

   function automatic longint sample_to_fixed(logic [31:0] w, logic [FMT_W-1:0] fmt);
      case (sample_format_type'(fmt))
         FMT_FLOAT32: return float_to_fixed(w);
         FMT_INT16:   return longint'($signed(w[15:0])) * 65536;
         FMT_INT24:   return longint'($signed(w[23:0])) * 256;
         FMT_INT32:   return longint'($signed(w));
         FMT_UINT8:   return (longint'(w[7:0]) - 128) * 16777216;
         default:     return 0;
      endcase
   endfunction

   // add one accepted channel sample; close the frame when the count is reached
   task automatic mix_channel_sample(logic [31:0] w, logic mark);
      int              chans;
      longint          mean;
      longint          scaled;
      mono_result_type r;
      chans = (count_copy == 0) ? 1 : ((count_copy > MAX_CH) ? MAX_CH : int'(count_copy));
      frame_sum = frame_sum + sample_to_fixed(w, fmt_copy);
      if (frame_sum > SUM_HI)
         frame_sum = SUM_HI;
      if (frame_sum < SUM_LO)
         frame_sum = SUM_LO;
      if (mark)
         frame_mark = 1'b1;
      frame_position++;
      if (frame_position >= chans) begin
         mean = frame_sum / chans;
         if (mean > UNIT_ONE)
            mean = UNIT_ONE;
         if (mean < -UNIT_ONE)
            mean = -UNIT_ONE;
         scaled = (mean * 32767) / UNIT_ONE;
         r.mono = scaled[MONO_W-1:0];
         r.mark = frame_mark;
         expected_mono = {expected_mono, r};
         frame_sum      = 0;
         frame_position = 0;
         frame_mark     = 1'b0;
      end
   endtask

   // driver: offers queued samples, predicts on each accepted transaction
   always @(posedge clock) begin : drive
      channel_sample_type nxt;
      bit fire;
      bit offer;
      fire = req_valid && req_ready;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (fire) begin
            mix_channel_sample(req_sample_word, req_packet_end_in);
            samples_accepted++;
         end
         if (!req_valid || fire) begin
            offer = (pending_samples.size() != 0) && ($urandom_range(99) >= send_idle_pct);
            if (offer && pending_samples[0].drain_first && expected_mono.size() != 0)
               offer = 1'b0;
            if (offer) begin
               nxt = pending_samples.pop_front();
               req_sample_word   <= nxt.word;
               req_packet_end_in <= nxt.mark;
            end
            req_valid <= offer;
         end
      end
   end

   // receiver and checker: random stalls, one long hold-off, in-order compare
   always @(posedge clock) begin : receive
      mono_result_type r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_mono.size() == 0) begin
            $display("%0t: unexpected mono sample %0d mark %0b", $realtime,
                     rsp_mono_sample, rsp_packet_end_out);
            mismatches++;
         end else begin
            r = expected_mono.pop_front();
            if (rsp_mono_sample !== r.mono) begin
               $display("%0t: mono_sample expected %0d got %0d", $realtime,
                        r.mono, rsp_mono_sample);
               mismatches++;
            end
            if (rsp_packet_end_out !== r.mark) begin
               $display("%0t: packet_end_out expected %0b got %0b", $realtime,
                        r.mark, rsp_packet_end_out);
               mismatches++;
            end
            frames_checked++;
         end
      end
      if (hold_request && !hold_started) begin
         hold_started = 1'b1;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d mono samples outstanding",
                  cycle_count, expected_mono.size());
         $display("pcm_downmix_to_mono16_core_tb failed");
         $finish;
      end
   end

   task automatic queue_sample(logic [31:0] w, logic mark, bit drain_first = 1'b0);
      channel_sample_type s;
      s.word        = w;
      s.mark        = mark;
      s.drain_first = drain_first;
      pending_samples = {pending_samples, s};
      samples_queued++;
   endtask

   // wait for all transactions to finish, then a settling margin
   task automatic settle();
      while (samples_accepted != samples_queued || expected_mono.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_SAMPLE_FORMAT)
         fmt_copy = data[FMT_W-1:0];
      else
         count_copy = data;
   endtask

   task automatic apply_config(logic [CSR_DATA_W-1:0] fmt, logic [CSR_DATA_W-1:0] chans);
      settle();
      write_reg(CSR_SAMPLE_FORMAT, fmt);
      write_reg(CSR_CHANNEL_COUNT, chans);
      settings_used++;
   endtask

   // float words: mostly audio range, plus denormals, inf/nan and large values
   function automatic logic [31:0] pick_float();
      logic sgn;
      sgn = 1'($urandom_range(1));
      case ($urandom_range(9))
         0, 1:    return $urandom;
         2:       return {sgn, 8'd0, 23'($urandom)};
         3:       return {sgn, 8'hFF, ($urandom_range(1) ? 23'd0 : 23'($urandom))};
         4:       return {sgn, 8'($urandom_range(119, 140)), 23'($urandom)};
         default: return {sgn, 8'($urandom_range(96, 127)), 23'($urandom)};
      endcase
   endfunction

   function automatic logic [31:0] pick_sample(logic [FMT_W-1:0] fmt);
      logic [31:0] corners [11];
      corners = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_7FFF,
                  32'h0000_8000, 32'h007F_FFFF, 32'h0080_0000, 32'h7F, 32'h80, 32'hFF};
      if (fmt == FMT_FLOAT32)
         return pick_float();
      if ($urandom_range(9) == 0)
         return corners[$urandom_range(10)];
      return $urandom;
   endfunction

   // one random phase: its own register setting and idling mode
   task automatic run_phase(int p);
      logic [CSR_DATA_W-1:0] fmt_w;
      logic [CSR_DATA_W-1:0] count_w;
      logic [CSR_DATA_W-1:0] count_corner [5];
      int n;
      count_corner = '{4'd0, 4'd1, 4'd8, 4'd15, 4'd1};
      fmt_w    = (p < 8) ? 4'(p) : 4'($urandom_range(7));
      fmt_w[3] = 1'($urandom_range(1));
      count_w  = (p < 5) ? count_corner[p] : 4'($urandom_range(15));
      apply_config(fmt_w, count_w);
      case (p % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
         default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      // long receiver hold-off while the sender keeps offering
      if (p == 4)
         hold_request = 1'b1;
      n = $urandom_range(50, 80);
      for (int i = 0; i < n; i++)
         queue_sample(pick_sample(fmt_w[FMT_W-1:0]), ($urandom_range(7) == 0),
                      (p == 5 && i == 30) || ($urandom_range(99) == 0));
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset setting int16 stereo: extremes, ignored upper bits, mark mid-frame
      settings_used = 1;
      queue_sample(32'h0000_7FFF, 1'b0);
      queue_sample(32'hABCD_7FFF, 1'b0);
      queue_sample(32'h0000_8000, 1'b1);
      queue_sample(32'hFFFF_8000, 1'b0);

      // float mono: nan, infinity, denormal, unity and saturation
      apply_config(4'd0, 4'd1);
      queue_sample(32'h7FC0_0001, 1'b0);
      queue_sample(32'hFF80_0000, 1'b1);
      queue_sample(32'h0000_0001, 1'b0);
      queue_sample(32'h3F80_0000, 1'b0);
      queue_sample(32'hBF80_0000, 1'b0);
      queue_sample(32'h4380_0000, 1'b0);

      // eight channels of +inf drive the sum into saturation
      apply_config(4'd8, 4'd8);
      for (int i = 0; i < 8; i++)
         queue_sample(32'h7F80_0000, (i == 7));

      // int24 with count zero, int32 and uint8 extremes, unsupported format
      apply_config(4'd2, 4'd0);
      queue_sample(32'h0080_0000, 1'b0);
      queue_sample(32'hFF7F_FFFF, 1'b1);
      apply_config(4'd3, 4'd1);
      queue_sample(32'h8000_0000, 1'b0);
      queue_sample(32'h7FFF_FFFF, 1'b0);
      apply_config(4'd4, 4'd1);
      queue_sample(32'h0000_0000, 1'b0);
      queue_sample(32'hFFFF_FFFF, 1'b1);
      apply_config(4'd5, 4'd1);
      queue_sample(32'h1234_5678, 1'b0);

      for (int p = 0; p < RANDOM_PHASES; p++)
         run_phase(p);

      // drain and give stray results a chance to show up
      while (samples_accepted != samples_queued || expected_mono.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d channel samples over %0d register settings",
               samples_accepted, settings_used);
      $display("checked %0d mono samples, %0d mismatches", frames_checked, mismatches);
      if (mismatches == 0)
         $display("pcm_downmix_to_mono16_core_tb passed");
      else
         $display("pcm_downmix_to_mono16_core_tb failed");
      $finish;
   end

endmodule
